/* src/ludec_pkg.sv */
package ludec_pkg;

    localparam int unsigned CpWidth = 21;
    localparam logic [CpWidth-1:0] Replacement = 21'h00FFFD;

    // one result word as it sits in the output queue
    typedef struct packed {
        logic [CpWidth-1:0] code_point;
        logic               is_replacement;
        logic               run_last;
    } result_t;

    // total length of the sequence a lead opens, zero when not a lead
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if ((b & 8'hE0) == 8'hC0) begin
            len = 3'd2;
        end else if ((b & 8'hF0) == 8'hE0) begin
            len = 3'd3;
        end else if ((b & 8'hF8) == 8'hF0) begin
            len = 3'd4;
        end
        return len;
    endfunction

    // a lone byte: ascii passes, anything else is replaced
    function automatic result_t single_result(input logic [7:0] b);
        result_t r;
        r.run_last = 1'b0;
        if (b < 8'h80) begin
            r.code_point     = {{(CpWidth-8){1'b0}}, b};
            r.is_replacement = 1'b0;
        end else begin
            r.code_point     = Replacement;
            r.is_replacement = 1'b1;
        end
        return r;
    endfunction

    function automatic result_t replacement_result();
        result_t r;
        r.code_point     = Replacement;
        r.is_replacement = 1'b1;
        r.run_last       = 1'b0;
        return r;
    endfunction

    function automatic result_t decoded_result(input logic [CpWidth-1:0] cp);
        result_t r;
        r.code_point     = cp;
        r.is_replacement = 1'b0;
        r.run_last       = 1'b0;
        return r;
    endfunction

endpackage

/* src/lenient_utf8_decoder.sv */
// Lenient UTF-8 decoder. Takes one text byte per word and returns code points. A byte
// is captured in an input register, decoded from that register against the pending
// lead state, and its results (none, one, or up to three for a terminator that flushes an
// unfinished sequence) are loaded into a three-entry output queue. The block sustains one
// byte per cycle while each byte yields at most one result and the output is ready; after
// a terminator flushing several results, the next byte with results waits while the output
// queue drains. A result passes the input register, then the output queue. Continuation bytes
// are not checked for the 10xxxxxx form; an unfinished sequence at the terminator gives 0xFFFD
// for its lead and the bytes after it are decoded again on their own.
module lenient_utf8_decoder
    import ludec_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_text_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [CpWidth-1:0] m_code_point,
    output logic               m_is_replacement,
    output logic               m_run_last
);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // decoder state: collected bytes, how many, and the open sequence length
    logic [7:0] pend_reg [3];
    logic [1:0] pcount_reg, pcount_next;
    logic [2:0] need_reg, need_next;
    logic       pend_wr;

    // output queue, head at entry zero
    result_t    res_reg [3];
    result_t    res_next [3];
    logic [1:0] cnt_reg, cnt_next;

    // results of the byte in the input register
    result_t    new_res [3];
    logic [1:0] new_k;
    logic       proc_fire;
    logic       pop;
    logic [CpWidth-1:0] asm_cp;

    // ---------------------------------------------------------------
    // handshakes
    // ---------------------------------------------------------------
    assign pop       = m_valid && m_ready;
    // a byte with no results never touches the queue, so it may go at once
    assign proc_fire = in_valid_reg &&
                       (new_k == 2'd0 || cnt_reg == 2'd0 || (cnt_reg == 2'd1 && m_ready));
    assign s_ready   = !in_valid_reg || proc_fire;

    assign m_valid          = (cnt_reg != 2'd0);
    assign m_code_point     = res_reg[0].code_point;
    assign m_is_replacement = res_reg[0].is_replacement;
    assign m_run_last       = res_reg[0].run_last;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------
    // assembling a completed sequence: lead payload then the six-bit groups
    // ---------------------------------------------------------------
    always_comb begin
        case (need_reg)
            3'd2: asm_cp = {10'd0, pend_reg[0][4:0], in_byte_reg[5:0]};
            3'd3: asm_cp = {5'd0, pend_reg[0][3:0], pend_reg[1][5:0], in_byte_reg[5:0]};
            default: asm_cp = {pend_reg[0][2:0], pend_reg[1][5:0], pend_reg[2][5:0],
                               in_byte_reg[5:0]};
        endcase
    end

    // ---------------------------------------------------------------
    // decode the held byte against the pending state
    // ---------------------------------------------------------------
    always_comb begin
        new_res[0]  = replacement_result();
        new_res[1]  = replacement_result();
        new_res[2]  = replacement_result();
        new_k       = 2'd0;
        pcount_next = pcount_reg;
        need_next   = need_reg;
        pend_wr     = 1'b0;

        if (in_byte_reg == 8'h00) begin
            // terminator: lead of an unfinished sequence is always short
            pcount_next = 2'd0;
            need_next   = 3'd0;
            case (pcount_reg)
                2'd1: begin
                    new_k = 2'd1;
                end
                2'd2: begin
                    new_res[1] = single_result(pend_reg[1]);
                    new_k      = 2'd2;
                end
                2'd3: begin
                    // the two trailing bytes may still form a two-byte sequence
                    if (lead_length(pend_reg[1]) == 3'd2) begin
                        new_res[1] = decoded_result({10'd0, pend_reg[1][4:0],
                                                     pend_reg[2][5:0]});
                        new_k      = 2'd2;
                    end else begin
                        new_res[1] = single_result(pend_reg[1]);
                        new_res[2] = single_result(pend_reg[2]);
                        new_k      = 2'd3;
                    end
                end
                default: begin
                    new_k = 2'd0;
                end
            endcase
        end else if (need_reg == 3'd0) begin
            if (lead_length(in_byte_reg) != 3'd0) begin
                pend_wr     = 1'b1;
                pcount_next = 2'd1;
                need_next   = lead_length(in_byte_reg);
            end else begin
                new_res[0] = single_result(in_byte_reg);
                new_k      = 2'd1;
            end
        end else if ({1'b0, pcount_reg} + 3'd1 >= need_reg) begin
            // last byte of the sequence
            new_res[0]  = decoded_result(asm_cp);
            new_k       = 2'd1;
            pcount_next = 2'd0;
            need_next   = 3'd0;
        end else begin
            pend_wr     = 1'b1;
            pcount_next = pcount_reg + 2'd1;
        end

        // flag the final result of this byte
        case (new_k)
            2'd1: new_res[0].run_last = 1'b1;
            2'd2: new_res[1].run_last = 1'b1;
            2'd3: new_res[2].run_last = 1'b1;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // output queue: reload on a new byte with results, else shift on pop
    // ---------------------------------------------------------------
    always_comb begin
        res_next[0] = res_reg[0];
        res_next[1] = res_reg[1];
        res_next[2] = res_reg[2];
        cnt_next    = cnt_reg;
        if (proc_fire && new_k != 2'd0) begin
            res_next[0] = new_res[0];
            res_next[1] = new_res[1];
            res_next[2] = new_res[2];
            cnt_next    = new_k;
        end else if (pop) begin
            res_next[0] = res_reg[1];
            res_next[1] = res_reg[2];
            cnt_next    = cnt_reg - 2'd1;
        end
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            pcount_reg   <= 2'd0;
            need_reg     <= 3'd0;
            cnt_reg      <= 2'd0;
        end else begin
            in_valid_reg <= in_valid_next;
            cnt_reg      <= cnt_next;
            if (proc_fire) begin
                pcount_reg <= pcount_next;
                need_reg   <= need_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_text_byte;
        end
        if (proc_fire && pend_wr) begin
            pend_reg[pcount_reg] <= in_byte_reg;
        end
        res_reg[0] <= res_next[0];
        res_reg[1] <= res_next[1];
        res_reg[2] <= res_next[2];
    end

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        need_reg == 3'd0 |-> pcount_reg == 2'd0)
        else $error("pending bytes with no open sequence");

    a_open_partial: assert property (@(posedge aclk) disable iff (!aresetn)
        need_reg != 3'd0 |-> pcount_reg != 2'd0 && {1'b0, pcount_reg} < need_reg)
        else $error("open sequence holds a wrong byte count");

    a_tail_last: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg == 2'd1 |-> res_reg[0].run_last)
        else $error("last queued result lacks run_last");

    a_held_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !proc_fire |-> !s_ready)
        else $error("input taken while the held byte is stuck");

endmodule
